// ===== hw/rtl/frp_pkg.sv =====
// frp_pkg: shared types and codes for the framed packet receiver
// no dependencies; used by frp_parser, frp_out_skid and framed_packet_receiver

package frp_pkg;

  // result status codes
  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_BYTE     = 3'd1;
  localparam logic [2:0] ST_OK       = 3'd2;
  localparam logic [2:0] ST_BAD_SUM  = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_LENGTH  = 2'd2;
  localparam int unsigned CFG_DATA_BITS = 16;

  // configuration register reset values
  localparam logic [7:0]  SYNC_FIRST_RST  = 8'd181;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'd98;
  localparam logic [15:0] MAX_LENGTH_RST  = 16'd1024;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_length;
  } frp_cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
    logic [15:0] errors_seen;
  } frp_result_t;

endpackage

// ===== hw/rtl/frp_parser.sv =====
// frp_parser: frame state machine, fletcher-8 sums and error tally
// depends on frp_pkg

module frp_parser #(
  parameter int unsigned ERROR_COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  frp_pkg::frp_cfg_t    cfg,
  output frp_pkg::frp_result_t result
);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_SYNC1   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_LEN_LO  = 4'd4;
  localparam logic [3:0] PH_LEN_HI  = 4'd5;
  localparam logic [3:0] PH_FIRST   = 4'd6;
  localparam logic [3:0] PH_PAYLOAD = 4'd7;
  localparam logic [3:0] PH_CHK_A   = 4'd8;
  localparam logic [3:0] PH_CHK_B   = 4'd9;

  localparam logic [ERROR_COUNT_BITS-1:0] TALLY_MAX = '1;

  logic [3:0]                  phase_r, phase_nxt;
  logic [7:0]                  sum_a_r, sum_a_nxt;
  logic [7:0]                  sum_b_r, sum_b_nxt;
  logic [7:0]                  class_r, class_nxt;
  logic [7:0]                  id_r, id_nxt;
  logic [15:0]                 length_r, length_nxt;
  logic [15:0]                 count_r, count_nxt;
  logic [ERROR_COUNT_BITS-1:0] tally_r, tally_nxt;
  logic [7:0]                  add_a, add_b;
  logic [15:0]                 count_inc;
  logic [2:0]                  status;
  logic [7:0]                  pbyte;
  logic [15:0]                 pindex;
  logic [15:0]                 errs;

  // running fletcher sums with the current byte folded in
  assign add_a     = sum_a_r + rx_byte;
  assign add_b     = sum_b_r + add_a;
  assign count_inc = count_r + 16'd1;

  always_comb begin
    phase_nxt  = phase_r;
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    class_nxt  = class_r;
    id_nxt     = id_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    tally_nxt  = tally_r;
    status     = frp_pkg::ST_NONE;
    pbyte      = 8'd0;
    pindex     = 16'd0;
    case (phase_r)
      PH_SYNC1: begin
        if (rx_byte == cfg.sync_second) begin
          phase_nxt = PH_CLASS;
          sum_a_nxt = 8'd0;
          sum_b_nxt = 8'd0;
        end else if (rx_byte != cfg.sync_first) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_CLASS: begin
        class_nxt = rx_byte;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        id_nxt    = rx_byte;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_nxt = {8'd0, rx_byte};
        sum_a_nxt  = add_a;
        sum_b_nxt  = add_b;
        phase_nxt  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_nxt = {rx_byte, length_r[7:0]};
        sum_a_nxt  = add_a;
        sum_b_nxt  = add_b;
        count_nxt  = 16'd0;
        phase_nxt  = PH_FIRST;
      end
      PH_FIRST, PH_PAYLOAD: begin
        if (phase_r == PH_FIRST && length_r >= cfg.max_length) begin
          if (tally_r != TALLY_MAX) begin
            tally_nxt = tally_r + 1'b1;
          end
          status    = frp_pkg::ST_TOO_LONG;
          phase_nxt = PH_IDLE;
        end else if (phase_r == PH_FIRST && length_r == 16'd0) begin
          status    = frp_pkg::ST_EMPTY;
          phase_nxt = PH_IDLE;
        end else begin
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          status    = frp_pkg::ST_BYTE;
          pbyte     = rx_byte;
          pindex    = count_r;
          count_nxt = count_inc;
          phase_nxt = (count_inc == length_r) ? PH_CHK_A : PH_PAYLOAD;
        end
      end
      PH_CHK_A: begin
        if (rx_byte == sum_a_r) begin
          phase_nxt = PH_CHK_B;
        end else begin
          status    = frp_pkg::ST_BAD_SUM;
          phase_nxt = PH_IDLE;
        end
      end
      PH_CHK_B: begin
        status    = (rx_byte == sum_b_r) ? frp_pkg::ST_OK : frp_pkg::ST_BAD_SUM;
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = (rx_byte == cfg.sync_first) ? PH_SYNC1 : PH_IDLE;
      end
    endcase
  end

  // clamp the tally to the 16-bit report
  generate
    if (ERROR_COUNT_BITS > 16) begin : g_clamp
      assign errs = (|tally_nxt[ERROR_COUNT_BITS-1:16]) ? 16'hFFFF : tally_nxt[15:0];
    end else begin : g_ext
      assign errs = 16'(tally_nxt);
    end
  endgenerate

  always_comb begin
    result.status        = status;
    result.payload_byte  = pbyte;
    result.payload_index = pindex;
    result.frame_class   = class_nxt;
    result.frame_id      = id_nxt;
    result.frame_length  = length_nxt;
    result.errors_seen   = errs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      sum_a_r  <= 8'd0;
      sum_b_r  <= 8'd0;
      class_r  <= 8'd0;
      id_r     <= 8'd0;
      length_r <= 16'd0;
      count_r  <= 16'd0;
      tally_r  <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      sum_a_r  <= sum_a_nxt;
      sum_b_r  <= sum_b_nxt;
      class_r  <= class_nxt;
      id_r     <= id_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
      tally_r  <= tally_nxt;
    end
  end

endmodule

// ===== hw/rtl/frp_out_skid.sv =====
// frp_out_skid: result register with one skid entry
// depends on frp_pkg

module frp_out_skid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  frp_pkg::frp_result_t push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output frp_pkg::frp_result_t out_data
);

  logic                 main_valid_r, main_valid_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  frp_pkg::frp_result_t main_r;
  frp_pkg::frp_result_t skid_r;
  logic                 pop;
  logic                 main_load;

  assign pop       = main_valid_r & ~out_stall;
  assign main_load = ~main_valid_r | pop;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (main_load) begin
      main_valid_nxt = skid_valid_r | push;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (main_load) begin
      main_r <= skid_valid_r ? skid_r : push_data;
    end
    if (!main_load && push) begin
      skid_r <= push_data;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

// ===== hw/rtl/framed_packet_receiver.sv =====
// framed_packet_receiver: top level of the sync/length/fletcher-8 frame parser
// depends on frp_pkg, frp_parser and frp_out_skid

// Takes one received byte per transfer and gives exactly one result per byte.
// A byte is taken in every cycle while out_stall allows: the parser state
// updates on the transfer and its result goes into an output register backed
// by one skid entry, so in_stall is a registered flag that rises only after
// the output side has held off for two results, and each result is registered.
// Frames are sync_first, sync_second, class, id, length (little endian),
// payload, check A, check B; the sums cover class through payload.
// Configuration is written through cfg_we/cfg_index/cfg_wdata only while no
// bytes are in flight: a rule for the user that the block does not enforce.

module framed_packet_receiver #(
  parameter int unsigned ERROR_COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [frp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [frp_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  // received byte channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_rx_byte,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_status,
  output logic [7:0]                        out_payload_byte,
  output logic [15:0]                       out_payload_index,
  output logic [7:0]                        out_frame_class,
  output logic [7:0]                        out_frame_id,
  output logic [15:0]                       out_frame_length,
  output logic [15:0]                       out_errors_seen
);

  frp_pkg::frp_cfg_t    cfg_r;
  frp_pkg::frp_result_t step_result;
  frp_pkg::frp_result_t out_data;
  logic                 in_xfer;
  logic                 skid_full;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= frp_pkg::SYNC_FIRST_RST;
      cfg_r.sync_second <= frp_pkg::SYNC_SECOND_RST;
      cfg_r.max_length  <= frp_pkg::MAX_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        frp_pkg::CFG_SYNC_FIRST:  cfg_r.sync_first  <= cfg_wdata[7:0];
        frp_pkg::CFG_SYNC_SECOND: cfg_r.sync_second <= cfg_wdata[7:0];
        frp_pkg::CFG_MAX_LENGTH:  cfg_r.max_length  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // input transfer advances the parser and pushes its result
  assign in_stall = skid_full;
  assign in_xfer  = in_valid & ~skid_full;

  frp_parser #(
    .ERROR_COUNT_BITS(ERROR_COUNT_BITS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_xfer),
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .result  (step_result)
  );

  frp_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_data (step_result),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_status        = out_data.status;
  assign out_payload_byte  = out_data.payload_byte;
  assign out_payload_index = out_data.payload_index;
  assign out_frame_class   = out_data.frame_class;
  assign out_frame_id      = out_data.frame_id;
  assign out_frame_length  = out_data.frame_length;
  assign out_errors_seen   = out_data.errors_seen;

`ifndef ASSERT_OFF
  // a held-off input means a result is already waiting
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall without a pending result");

  // a transfer into a free output path shows a result next cycle
  a_xfer_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted byte produced no result");

  // payload index stays inside the declared length
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == frp_pkg::ST_BYTE) |-> out_payload_index < out_frame_length)
    else $error("payload index beyond frame length");

  // payload fields are zero unless a payload byte is reported
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != frp_pkg::ST_BYTE)
      |-> (out_payload_byte == 8'd0 && out_payload_index == 16'd0))
    else $error("payload fields set on non-payload result");
`endif

endmodule
